FILE: hw/rtl/lzr_pkg.sv
// shared types and constants for the refpack stream decoder
`timescale 1ns / 1ps
package lzr_pkg;

  // stream parse phases
  typedef enum logic [2:0] {
    PH_FLAG1  = 3'd0,
    PH_FLAG2  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_LEN    = 3'd3,
    PH_CMD    = 3'd4,
    PH_LIT    = 3'd5,
    PH_ENDLIT = 3'd6
  } lzr_phase_t;

  localparam int unsigned PACK_BYTES = 32;
  localparam int unsigned LIT_RUN_MAX = 112;

  // commands from controller to datapath
  typedef struct packed {
    logic parse;
    logic append;
    logic sel_copy;
    logic rd;
    logic abort;
    logic emit;
    logic emit_last;
    logic fin_clear;
  } lzr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic act_lit;
    logic act_copy;
    logic copy_ok;
    logic copy_last;
    logic pack_full;
    logic pack_any;
    logic flag_any;
    logic out_free;
  } lzr_stat_t;

endpackage

FILE: hw/rtl/lzr_ctrl.sv
// sequencing state machine for the refpack stream decoder
`timescale 1ns / 1ps
module lzr_ctrl
  import lzr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  lzr_stat_t stat,
  output lzr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_CHK,
    S_CRD,
    S_CWR,
    S_FIN
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.parse = 1'b1;
          state_next = S_LIT;
        end
      end
      S_LIT: begin
        if (!stat.act_lit) begin
          state_next = S_CHK;
        end else if (stat.pack_full) begin
          cmd.emit = stat.out_free;
        end else begin
          cmd.append = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.act_copy && stat.copy_ok) begin
          state_next = S_CRD;
        end else begin
          cmd.abort = stat.act_copy;
          state_next = S_FIN;
        end
      end
      S_CRD: begin
        cmd.rd = 1'b1;
        state_next = S_CWR;
      end
      S_CWR: begin
        if (stat.pack_full) begin
          cmd.emit = stat.out_free;
        end else begin
          cmd.append = 1'b1;
          cmd.sel_copy = 1'b1;
          state_next = stat.copy_last ? S_FIN : S_CRD;
        end
      end
      S_FIN: begin
        if (stat.pack_any || stat.flag_any) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.fin_clear = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.fin_clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/lzr_dp.sv
// parse registers, history memory, result packing and output register
`timescale 1ns / 1ps
module lzr_dp
  import lzr_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  lzr_cmd_t    cmd,
  output lzr_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes_0,
  output logic [63:0] out_bytes_1,
  output logic [63:0] out_bytes_2,
  output logic [63:0] out_bytes_3,
  output logic [5:0]  byte_count,
  output logic        run_last,
  output logic        header_done,
  output logic [31:0] declared_length,
  output logic        stream_done,
  output logic [31:0] consumed_bytes,
  output logic        copy_error
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] WIN = PW'(WINDOW_BYTES);

  // parse state
  lzr_phase_t  phase, phase_next;
  logic [2:0]  field_counter, field_counter_next;
  logic [15:0] flag_word, flag_word_next;
  logic [31:0] command_bytes, command_bytes_next;
  logic [6:0]  literals_left, literals_left_next;
  logic [10:0] copy_length, copy_length_next;
  logic [17:0] copy_distance, copy_distance_next;
  logic [31:0] length_word, length_word_next;
  logic [31:0] consumed_count, consumed_inc;
  logic        lit_next, copy_next, hdr_next, done_next;

  // per-item flags
  logic        act_lit, act_copy, hdr_f, done_f, err_f;
  logic [7:0]  lit_byte;
  logic [31:0] hdr_len, cons_rep;

  // history
  logic [7:0]    hist [WINDOW_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] write_pointer;
  logic [PW-1:0] produced_count;
  logic [PW-1:0] dist_w, wp_w, src_w;
  logic [7:0]    app_byte;

  // result packing
  logic [8*PACK_BYTES-1:0] pack;
  logic [5:0]              pack_cnt;

  logic [7:0]  first_b;
  logic [2:0]  need;
  logic [7:0]  run;

  assign consumed_inc = (consumed_count == 32'hFFFF_FFFF) ? consumed_count
                                                          : consumed_count + 32'd1;

  always_comb begin
    phase_next = phase;
    field_counter_next = field_counter;
    flag_word_next = flag_word;
    command_bytes_next = command_bytes;
    literals_left_next = literals_left;
    copy_length_next = copy_length;
    copy_distance_next = copy_distance;
    length_word_next = length_word;
    lit_next = 1'b0;
    copy_next = 1'b0;
    hdr_next = 1'b0;
    done_next = 1'b0;
    first_b = 8'd0;
    need = 3'd1;
    run = 8'd0;
    case (phase)
      PH_FLAG1: begin
        flag_word_next = {in_byte, 8'h00};
        phase_next = PH_FLAG2;
      end
      PH_FLAG2: begin
        flag_word_next = {flag_word[15:8], in_byte};
        length_word_next = '0;
        field_counter_next = flag_word_next[15] ? 3'd4 : 3'd3;
        phase_next = flag_word_next[8] ? PH_SKIP : PH_LEN;
      end
      PH_SKIP: begin
        field_counter_next = field_counter - 3'd1;
        if (field_counter_next == 3'd0) begin
          field_counter_next = flag_word[15] ? 3'd4 : 3'd3;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        length_word_next = {length_word[23:0], in_byte};
        field_counter_next = field_counter - 3'd1;
        if (field_counter_next == 3'd0) begin
          hdr_next = 1'b1;
          phase_next = PH_CMD;
          command_bytes_next = '0;
        end
      end
      PH_CMD: begin
        command_bytes_next = {command_bytes[23:0], in_byte};
        field_counter_next = field_counter + 3'd1;
        case (field_counter_next)
          3'd1:    first_b = command_bytes_next[7:0];
          3'd2:    first_b = command_bytes_next[15:8];
          3'd3:    first_b = command_bytes_next[23:16];
          default: first_b = command_bytes_next[31:24];
        endcase
        if (!first_b[7])      need = 3'd2;
        else if (!first_b[6]) need = 3'd3;
        else if (!first_b[5]) need = 3'd4;
        else                  need = 3'd1;
        if (field_counter_next >= need) begin
          field_counter_next = '0;
          case (need)
            3'd1: begin
              run = {1'b0, first_b[4:0], 2'b00} + 8'd4;
              if (run <= 8'(LIT_RUN_MAX)) begin
                literals_left_next = run[6:0];
                copy_length_next = '0;
                phase_next = PH_LIT;
              end else begin
                literals_left_next = {5'd0, first_b[1:0]};
                if (first_b[1:0] == 2'd0) done_next = 1'b1;
                else phase_next = PH_ENDLIT;
              end
            end
            3'd2: begin
              literals_left_next = {5'd0, first_b[1:0]};
              copy_distance_next = {8'd0, first_b[6:5], command_bytes_next[7:0]} + 18'd1;
              copy_length_next = {8'd0, first_b[4:2]} + 11'd3;
            end
            3'd3: begin
              literals_left_next = {5'd0, command_bytes_next[15:14]};
              copy_distance_next = {4'd0, command_bytes_next[13:0]} + 18'd1;
              copy_length_next = {5'd0, first_b[5:0]} + 11'd4;
            end
            default: begin
              literals_left_next = {5'd0, first_b[1:0]};
              copy_distance_next = {1'b0, first_b[4], command_bytes_next[23:8]} + 18'd1;
              copy_length_next = {1'b0, first_b[3:2], command_bytes_next[7:0]} + 11'd5;
            end
          endcase
          command_bytes_next = '0;
          if (need != 3'd1) begin
            if (literals_left_next != 7'd0) phase_next = PH_LIT;
            else copy_next = 1'b1;
          end
        end
      end
      PH_LIT: begin
        lit_next = 1'b1;
        if (literals_left != 7'd0) literals_left_next = literals_left - 7'd1;
        if (literals_left_next == 7'd0) begin
          copy_next = (copy_length != 11'd0);
          phase_next = PH_CMD;
          field_counter_next = '0;
          command_bytes_next = '0;
        end
      end
      default: begin
        lit_next = 1'b1;
        if (literals_left != 7'd0) literals_left_next = literals_left - 7'd1;
        if (literals_left_next == 7'd0) done_next = 1'b1;
      end
    endcase
    if (done_next) begin
      phase_next = PH_FLAG1;
      field_counter_next = '0;
      flag_word_next = '0;
      command_bytes_next = '0;
      literals_left_next = '0;
      copy_length_next = '0;
      copy_distance_next = '0;
      length_word_next = '0;
    end
  end

  // copy source, wrapped into the window
  assign dist_w = PW'(copy_distance);
  assign wp_w = PW'(write_pointer);
  assign src_w = (wp_w >= dist_w) ? (wp_w - dist_w) : (wp_w + WIN - dist_w);
  assign app_byte = cmd.sel_copy ? rd_data : lit_byte;

  assign stat.act_lit = act_lit;
  assign stat.act_copy = act_copy;
  assign stat.copy_ok = (copy_distance != 18'd0) && (copy_distance <= 18'(produced_count));
  assign stat.copy_last = (copy_length == 11'd1);
  assign stat.pack_full = (pack_cnt == 6'(PACK_BYTES));
  assign stat.pack_any = (pack_cnt != 6'd0);
  assign stat.flag_any = hdr_f | done_f | err_f;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      hist[write_pointer] <= app_byte;
    end
    if (cmd.rd) begin
      rd_data <= hist[src_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG1;
      field_counter <= '0;
      flag_word <= '0;
      command_bytes <= '0;
      literals_left <= '0;
      copy_length <= '0;
      copy_distance <= '0;
      length_word <= '0;
      consumed_count <= '0;
      write_pointer <= '0;
      produced_count <= '0;
      act_lit <= 1'b0;
      act_copy <= 1'b0;
      hdr_f <= 1'b0;
      done_f <= 1'b0;
      err_f <= 1'b0;
      pack <= '0;
      pack_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.parse) begin
        phase <= phase_next;
        field_counter <= field_counter_next;
        flag_word <= flag_word_next;
        command_bytes <= command_bytes_next;
        literals_left <= literals_left_next;
        copy_length <= copy_length_next;
        copy_distance <= copy_distance_next;
        length_word <= length_word_next;
        consumed_count <= done_next ? 32'd0 : consumed_inc;
        cons_rep <= consumed_inc;
        hdr_len <= length_word_next;
        lit_byte <= in_byte;
        act_lit <= lit_next;
        act_copy <= copy_next;
        hdr_f <= hdr_next;
        done_f <= done_next;
        err_f <= 1'b0;
      end
      if (cmd.abort) begin
        err_f <= 1'b1;
        copy_length <= '0;
      end
      if (cmd.append) begin
        write_pointer <= (32'(write_pointer) + 32'd1 >= WINDOW_BYTES) ? '0
                                                                    : write_pointer + 1'b1;
        if (produced_count < WIN) produced_count <= produced_count + 1'b1;
        pack[8*pack_cnt[4:0] +: 8] <= app_byte;
        pack_cnt <= pack_cnt + 6'd1;
        if (cmd.sel_copy) copy_length <= copy_length - 11'd1;
      end
      if (cmd.fin_clear) begin
        if (done_f) begin
          write_pointer <= '0;
          produced_count <= '0;
        end
        act_lit <= 1'b0;
        act_copy <= 1'b0;
      end
      if (cmd.emit) begin
        pack <= '0;
        pack_cnt <= '0;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded from the pack buffer
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bytes_0 <= pack[63:0];
      out_bytes_1 <= pack[127:64];
      out_bytes_2 <= pack[191:128];
      out_bytes_3 <= pack[255:192];
      byte_count <= pack_cnt;
      run_last <= cmd.emit_last;
      header_done <= cmd.emit_last & hdr_f;
      declared_length <= (cmd.emit_last && hdr_f) ? hdr_len : 32'd0;
      stream_done <= cmd.emit_last & done_f;
      consumed_bytes <= (cmd.emit_last && done_f) ? cons_rep : 32'd0;
      copy_error <= cmd.emit_last & err_f;
    end
  end

endmodule

FILE: hw/rtl/lz_refpack_stream_decoder_core.sv
// top level of the refpack stream decoder
//
//  channel | signals                               | handshake
//  input   | in_byte                               | in_valid / in_stall
//  output  | out_bytes_0..3, byte_count, flags ... | out_valid / out_stall
//
// every item passes through accept, literal slot, copy check and finish
// each copied byte takes a registered history read and then a write
// each full group of 32 bytes is handed to the output register before the item goes on
// input is stalled until all results of the current item are in the output register
// synchronous reset clears control state; the history memory is not cleared
`timescale 1ns / 1ps
module lz_refpack_stream_decoder_core
  import lzr_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes_0,
  output logic [63:0] out_bytes_1,
  output logic [63:0] out_bytes_2,
  output logic [63:0] out_bytes_3,
  output logic [5:0]  byte_count,
  output logic        run_last,
  output logic        header_done,
  output logic [31:0] declared_length,
  output logic        stream_done,
  output logic [31:0] consumed_bytes,
  output logic        copy_error
);

  lzr_cmd_t  cmd;
  lzr_stat_t stat;

  lzr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzr_dp #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (in_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bytes_0     (out_bytes_0),
    .out_bytes_1     (out_bytes_1),
    .out_bytes_2     (out_bytes_2),
    .out_bytes_3     (out_bytes_3),
    .byte_count      (byte_count),
    .run_last        (run_last),
    .header_done     (header_done),
    .declared_length (declared_length),
    .stream_done     (stream_done),
    .consumed_bytes  (consumed_bytes),
    .copy_error      (copy_error)
  );

endmodule

FILE: tb/lz_refpack_stream_decoder_core_tb.sv
// self-checking testbench for the refpack stream decoder core
`timescale 1ns / 1ps
module lz_refpack_stream_decoder_core_tb;
  import lzr_pkg::*;

  localparam int unsigned WIN = 131072;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned RAND_ITEMS = 480;

  typedef struct {
    logic [255:0] data;
    logic [5:0]   cnt;
    logic         last;
    logic         hdr;
    logic [31:0]  dlen;
    logic         done;
    logic [31:0]  cons;
    logic         err;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_bytes_0, out_bytes_1, out_bytes_2, out_bytes_3;
  logic [5:0]  byte_count;
  logic        run_last, header_done, stream_done, copy_error;
  logic [31:0] declared_length, consumed_bytes;

  lz_refpack_stream_decoder_core uut (.*);

  always #4 clk = ~clk;

  // stimulus and expectation stores
  logic [7:0]  byte_queue[$];
  dec_result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned accepted_items = 0;
  int unsigned idle_cycles = 0;
  bit          took_item = 1'b0;
  bit          stim_done = 1'b0;

  // decoder state mirror
  lzr_phase_t  st_phase;
  logic [2:0]  fld_cnt;
  logic [15:0] flags;
  logic [31:0] cmd_acc;
  logic [6:0]  lit_left;
  logic [10:0] cp_len;
  logic [17:0] cp_dist;
  logic [7:0]  hist[0:WIN-1];
  logic [16:0] wr_ptr;
  logic [17:0] prod_cnt;
  logic [31:0] cons_cnt;
  logic [31:0] len_acc;
  logic [7:0]  pend_buf[0:1039];
  int unsigned pend_n;

  task automatic clear_stream();
    st_phase = PH_FLAG1;
    fld_cnt = 0; flags = 0; cmd_acc = 0; lit_left = 0; cp_len = 0; cp_dist = 0;
    wr_ptr = 0; prod_cnt = 0; cons_cnt = 0; len_acc = 0;
  endtask

  function automatic void emit_byte(input logic [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = (wr_ptr == WIN - 1) ? 17'd0 : wr_ptr + 17'd1;
    if (prod_cnt < WIN) prod_cnt = prod_cnt + 18'd1;
    pend_buf[pend_n] = b;
    pend_n++;
  endfunction

  // returns 1 when the copy is skipped
  function automatic bit back_copy();
    int unsigned src;
    bit skipped;
    skipped = 1'b0;
    if (cp_dist == 0 || cp_dist > prod_cnt) begin
      skipped = 1'b1;
    end else begin
      for (int i = 0; i < cp_len; i++) begin
        src = (wr_ptr >= cp_dist) ? wr_ptr - cp_dist : wr_ptr + WIN - cp_dist;
        emit_byte(hist[src]);
      end
    end
    cp_len = 0;
    return skipped;
  endfunction

  task automatic decode_item(input logic [7:0] b);
    bit hdr, done, err;
    logic [31:0] cons_rep;
    logic [7:0] first, c2, c3, c4;
    int unsigned need, run, nres, base, cnt;
    dec_result_t r;
    hdr = 0; done = 0; err = 0; cons_rep = 0; pend_n = 0;
    if (cons_cnt != 32'hFFFF_FFFF) cons_cnt++;
    case (st_phase)
      PH_FLAG1: begin
        flags = {b, 8'h00};
        st_phase = PH_FLAG2;
      end
      PH_FLAG2: begin
        flags[7:0] = b;
        len_acc = 0;
        fld_cnt = flags[15] ? 3'd4 : 3'd3;
        st_phase = flags[8] ? PH_SKIP : PH_LEN;
      end
      PH_SKIP: begin
        fld_cnt--;
        if (fld_cnt == 0) begin
          fld_cnt = flags[15] ? 3'd4 : 3'd3;
          st_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        len_acc = {len_acc[23:0], b};
        fld_cnt--;
        if (fld_cnt == 0) begin
          hdr = 1;
          st_phase = PH_CMD;
          cmd_acc = 0;
        end
      end
      PH_CMD: begin
        cmd_acc = {cmd_acc[23:0], b};
        fld_cnt++;
        first = cmd_acc >> (8 * (fld_cnt - 1));
        need = !first[7] ? 2 : !first[6] ? 3 : !first[5] ? 4 : 1;
        if (fld_cnt >= need) begin
          fld_cnt = 0;
          c2 = cmd_acc >> (8 * (need - 2));
          c3 = cmd_acc >> (8 * (need - 3));
          c4 = cmd_acc[7:0];
          cmd_acc = 0;
          if (need == 1) begin
            run = (first[4:0] << 2) + 4;
            if (run <= LIT_RUN_MAX) begin
              lit_left = run;
              cp_len = 0;
              st_phase = PH_LIT;
            end else begin
              lit_left = first[1:0];
              if (lit_left == 0) done = 1;
              else st_phase = PH_ENDLIT;
            end
          end else begin
            if (need == 2) begin
              lit_left = first[1:0];
              cp_dist = {first[6:5], c2} + 18'd1;
              cp_len = first[4:2] + 11'd3;
            end else if (need == 3) begin
              lit_left = c2[7:6];
              cp_dist = {c2[5:0], c3} + 18'd1;
              cp_len = first[5:0] + 11'd4;
            end else begin
              lit_left = first[1:0];
              cp_dist = {first[4], c2, c3} + 18'd1;
              cp_len = {first[3:2], c4} + 11'd5;
            end
            if (lit_left != 0) st_phase = PH_LIT;
            else err = back_copy();
          end
        end
      end
      PH_LIT: begin
        emit_byte(b);
        if (lit_left != 0) lit_left--;
        if (lit_left == 0) begin
          if (cp_len != 0) err = back_copy();
          st_phase = PH_CMD;
          fld_cnt = 0;
          cmd_acc = 0;
        end
      end
      default: begin
        emit_byte(b);
        if (lit_left != 0) lit_left--;
        if (lit_left == 0) done = 1;
      end
    endcase
    if (done) begin
      cons_rep = cons_cnt;
      clear_stream();
    end
    if (pend_n != 0 || hdr || done || err) begin
      nres = (pend_n == 0) ? 1 : (pend_n + 31) / 32;
      for (int k = 0; k < nres; k++) begin
        base = k * 32;
        cnt = (pend_n > base) ? pend_n - base : 0;
        if (cnt > 32) cnt = 32;
        r.data = '0;
        for (int i = 0; i < cnt; i++) r.data[8*i +: 8] = pend_buf[base + i];
        r.cnt = cnt;
        r.last = (k + 1 == nres);
        r.hdr = r.last & hdr;
        r.dlen = (r.last && hdr) ? len_acc : 32'd0;
        r.done = r.last & done;
        r.cons = (r.last && done) ? cons_rep : 32'd0;
        r.err = r.last & err;
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [255:0] got,
                                 input logic [255:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // stream builder with a running count of produced bytes
  int unsigned gen_prod;

  task automatic push_lits(input int unsigned n);
    for (int i = 0; i < n; i++) byte_queue.push_back($urandom_range(0, 255));
    gen_prod += n;
  endtask

  function automatic int unsigned pick_dist(input int unsigned max_d);
    int unsigned lim;
    lim = (gen_prod < max_d) ? gen_prod : max_d;
    if (lim == 0 || $urandom_range(0, 9) == 0) return $urandom_range(1, max_d);
    return $urandom_range(1, lim);
  endfunction

  task automatic gen_stream(input int unsigned n_cmds);
    logic [7:0] f1;
    int unsigned d, len, lits, kind;
    f1 = $urandom_range(0, 255);
    gen_prod = 0;
    byte_queue.push_back(f1);
    byte_queue.push_back($urandom_range(0, 255));
    if (f1[0]) repeat (f1[7] ? 4 : 3) byte_queue.push_back($urandom_range(0, 255));
    repeat (f1[7] ? 4 : 3) byte_queue.push_back($urandom_range(0, 255));
    repeat (n_cmds) begin
      kind = $urandom_range(0, 99);
      lits = $urandom_range(0, 3);
      if (kind < 25) begin
        len = $urandom_range(0, 27);
        byte_queue.push_back(8'hE0 | len[4:0]);
        push_lits(len * 4 + 4);
      end else if (kind < 50) begin
        d = pick_dist(1024) - 1;
        len = $urandom_range(0, 7);
        byte_queue.push_back({1'b0, d[9:8], len[2:0], lits[1:0]});
        byte_queue.push_back(d[7:0]);
        push_lits(lits);
        if (d + 1 <= gen_prod) gen_prod += len + 3;
      end else if (kind < 75) begin
        d = pick_dist(16384) - 1;
        len = $urandom_range(0, 63);
        byte_queue.push_back({2'b10, len[5:0]});
        byte_queue.push_back({lits[1:0], d[13:8]});
        byte_queue.push_back(d[7:0]);
        push_lits(lits);
        if (d + 1 <= gen_prod) gen_prod += len + 4;
      end else if (kind < 93) begin
        d = pick_dist(WIN) - 1;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
        byte_queue.push_back({3'b110, d[16], len[9:8], lits[1:0]});
        byte_queue.push_back(d[15:8]);
        byte_queue.push_back(d[7:0]);
        byte_queue.push_back(len[7:0]);
        push_lits(lits);
        if (d + 1 <= gen_prod) gen_prod += len + 5;
      end else begin
        // noise byte: anything, the mirror follows wherever it leads
        byte_queue.push_back($urandom_range(0, 255));
      end
    end
    lits = $urandom_range(0, 3);
    byte_queue.push_back(8'hFC | lits[1:0]);
    push_lits(lits);
  endtask

  // sender: bursts with gaps
  int unsigned burst_left = 4, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took_item) begin
      // hold the stalled item
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (byte_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_byte <= byte_queue.pop_front();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern changing by mode, plus one long hold-off
  int unsigned hold_left = 0, mode_cycles = 0, stall_mode = 0;
  bit hold_started = 1'b0;
  always @(negedge clk) begin
    if (!hold_started && accepted_items >= 150) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    mode_cycles++;
    if (mode_cycles >= 64) begin
      mode_cycles = 0;
      stall_mode = $urandom_range(0, 2);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // acceptance, prediction, checking and watchdog
  always @(posedge clk) begin
    dec_result_t w;
    logic [255:0] got;
    took_item = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        took_item = 1'b1;
        accepted_items++;
        idle_cycles = 0;
        decode_item(in_byte);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got = {out_bytes_3, out_bytes_2, out_bytes_1, out_bytes_0};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", got, '0);
        end else begin
          w = expected_results.pop_front();
          if (got !== w.data) report_mismatch("out_bytes", got, w.data);
          if (byte_count !== w.cnt) report_mismatch("byte_count", byte_count, w.cnt);
          if (run_last !== w.last) report_mismatch("run_last", run_last, w.last);
          if (header_done !== w.hdr) report_mismatch("header_done", header_done, w.hdr);
          if (declared_length !== w.dlen)
            report_mismatch("declared_length", declared_length, w.dlen);
          if (stream_done !== w.done) report_mismatch("stream_done", stream_done, w.done);
          if (consumed_bytes !== w.cons)
            report_mismatch("consumed_bytes", consumed_bytes, w.cons);
          if (copy_error !== w.err) report_mismatch("copy_error", copy_error, w.err);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    clear_stream();
    // directed: skip header, min literal block, overlapping copy,
    // copy too far, end marker with a literal
    byte_queue = '{8'h11, 8'hFB, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h12, 8'h34,
                   8'hE0, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h00, 8'h00,
                   8'hBF, 8'h3F, 8'hFF, 8'hFD, 8'h77};
    gen_prod = 0;
    // long header, max literal block, longest copy, then bare end marker
    byte_queue.push_back(8'h80); byte_queue.push_back(8'h00);
    repeat (4) byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'hFB);
    push_lits(112);
    byte_queue.push_back(8'hCC); byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h00); byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'hFC);
    while (byte_queue.size() < RAND_ITEMS) gen_stream($urandom_range(3, 20));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (byte_queue.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: lz_refpack_stream_decoder_core.f
hw/rtl/lzr_pkg.sv
hw/rtl/lzr_ctrl.sv
hw/rtl/lzr_dp.sv
hw/rtl/lz_refpack_stream_decoder_core.sv
tb/lz_refpack_stream_decoder_core_tb.sv
